// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// hct_pkg
// Widths, register codes, reset values and shared types of the thermostat.
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int TEMP_W = 12;
  localparam int AGE_W  = 16;
  localparam int HYST_W = 8;
  localparam int MIN_W  = 16;
  // Band edges are limit +/- hysteresis, kept exact with two spare bits.
  localparam int BAND_W = TEMP_W + 2;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LOWER_LIMIT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_HEATER_ON  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_HEATER_OFF = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_COOLER_ON  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_COOLER_OFF = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LIMITS_VALID   = 3'd7;

  localparam logic [HYST_W-1:0] HYST_RESET = 8'd3;
  localparam logic [MIN_W-1:0]  MIN_RESET  = 16'd10;

  typedef struct packed {
    logic signed [TEMP_W-1:0] lower_limit;
    logic signed [TEMP_W-1:0] upper_limit;
    logic [HYST_W-1:0]        hysteresis;
    logic [MIN_W-1:0]         min_heater_on;
    logic [MIN_W-1:0]         min_heater_off;
    logic [MIN_W-1:0]         min_cooler_on;
    logic [MIN_W-1:0]         min_cooler_off;
    logic                     limits_valid;
  } hct_cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] stored_temperature;
    logic                     reading_seen;
    logic                     heater_state;
    logic                     cooler_state;
    logic [AGE_W-1:0]         heater_on_age;
    logic [AGE_W-1:0]         heater_off_age;
    logic [AGE_W-1:0]         cooler_on_age;
    logic [AGE_W-1:0]         cooler_off_age;
  } hct_state_t;

  typedef struct packed {
    logic       heater_drive;
    logic       cooler_drive;
    logic [3:0] relay_mask;
    logic       drive_changed;
    logic       evaluated;
  } hct_result_t;

endpackage

// File: rtl/hct_step.sv
// ----------------------------------------------------------------------------
// hct_step
// One item of thermostat work: store a reading, or age the counters and
// apply the hysteresis and minimum run time rules.
// ----------------------------------------------------------------------------
module hct_step (
  input  hct_pkg::hct_cfg_t                  cfg,
  input  hct_pkg::hct_state_t                st,
  input  logic                               mode,
  input  logic signed [hct_pkg::TEMP_W-1:0]  temperature,
  output hct_pkg::hct_state_t                st_next,
  output hct_pkg::hct_result_t               result
);

  logic signed [hct_pkg::BAND_W-1:0] t_x;
  logic signed [hct_pkg::BAND_W-1:0] h_x;
  logic signed [hct_pkg::BAND_W-1:0] lo_minus;
  logic signed [hct_pkg::BAND_W-1:0] lo_plus;
  logic signed [hct_pkg::BAND_W-1:0] hi_minus;
  logic signed [hct_pkg::BAND_W-1:0] hi_plus;
  logic want_heat;
  logic want_cool;
  logic long_enough;
  logic rested;
  logic run;
  hct_pkg::hct_state_t aged;
  hct_pkg::hct_state_t ns;

  function automatic logic [hct_pkg::AGE_W-1:0] age_inc(input logic [hct_pkg::AGE_W-1:0] a);
    age_inc = (a == hct_pkg::AGE_MAX) ? a : a + 1'b1;
  endfunction

  always_comb begin
    t_x      = hct_pkg::BAND_W'(st.stored_temperature);
    h_x      = hct_pkg::BAND_W'($signed({1'b0, cfg.hysteresis}));
    lo_minus = hct_pkg::BAND_W'(cfg.lower_limit) - h_x;
    lo_plus  = hct_pkg::BAND_W'(cfg.lower_limit) + h_x;
    hi_minus = hct_pkg::BAND_W'(cfg.upper_limit) - h_x;
    hi_plus  = hct_pkg::BAND_W'(cfg.upper_limit) + h_x;
    want_heat = (t_x <= lo_minus);
    want_cool = (t_x >= hi_plus);
  end

  always_comb begin
    aged = st;
    aged.heater_on_age  = age_inc(st.heater_on_age);
    aged.heater_off_age = age_inc(st.heater_off_age);
    aged.cooler_on_age  = age_inc(st.cooler_on_age);
    aged.cooler_off_age = age_inc(st.cooler_off_age);

    run = mode && st.reading_seen && cfg.limits_valid;
    long_enough = 1'b0;
    rested = 1'b0;

    if (!mode) begin
      ns = st;
      ns.stored_temperature = temperature;
      ns.reading_seen = 1'b1;
    end else begin
      ns = aged;
      if (run) begin
        if (aged.heater_state) begin
          long_enough = (aged.heater_on_age >= cfg.min_heater_on);
          rested = (aged.cooler_off_age >= cfg.min_cooler_off);
          if (long_enough && (t_x >= lo_plus)) begin
            ns.heater_state = 1'b0;
            ns.heater_off_age = '0;
          end else if (long_enough && want_cool && rested) begin
            ns.heater_state = 1'b0;
            ns.heater_off_age = '0;
            ns.cooler_state = 1'b1;
            ns.cooler_on_age = '0;
          end
        end else if (aged.cooler_state) begin
          long_enough = (aged.cooler_on_age >= cfg.min_cooler_on);
          rested = (aged.heater_off_age >= cfg.min_heater_off);
          if (long_enough && (t_x <= hi_minus)) begin
            ns.cooler_state = 1'b0;
            ns.cooler_off_age = '0;
          end else if (long_enough && want_heat && rested) begin
            ns.cooler_state = 1'b0;
            ns.cooler_off_age = '0;
            ns.heater_state = 1'b1;
            ns.heater_on_age = '0;
          end
        end else begin
          if (want_heat && (aged.heater_off_age >= cfg.min_heater_off)) begin
            ns.heater_state = 1'b1;
            ns.heater_on_age = '0;
          end else if (want_cool && (aged.cooler_off_age >= cfg.min_cooler_off)) begin
            ns.cooler_state = 1'b1;
            ns.cooler_on_age = '0;
          end
        end
      end
    end
  end

  always_comb begin
    st_next = ns;
    result.heater_drive  = ns.heater_state;
    result.cooler_drive  = ns.cooler_state;
    result.relay_mask    = {ns.cooler_state, ns.cooler_state,
                            ns.heater_state, ns.heater_state};
    result.drive_changed = (ns.heater_state != st.heater_state) ||
                           (ns.cooler_state != st.cooler_state);
    result.evaluated     = run;
  end

endmodule

// File: rtl/heat_cool_thermostat.sv
// ----------------------------------------------------------------------------
// heat_cool_thermostat
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle; hct_step settles in one combinational pass
// between the state register and the result register. A result held by low
// out_ready stalls the input until it is taken, which may be in the same cycle.
// Reset (synchronous, rst high): all registers but the result payload return to
// their reset values, the drive states are off, the ages and the stored reading are cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heat_cool_thermostat (
  input  logic                               clk,
  input  logic                               rst,
  // Item input channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic signed [hct_pkg::TEMP_W-1:0]  temperature,
  // Result output channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               heater_drive,
  output logic                               cooler_drive,
  output logic [3:0]                         relay_mask,
  output logic                               drive_changed,
  output logic                               evaluated,
  // APB-style configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  hct_pkg::hct_cfg_t    cfg;
  hct_pkg::hct_state_t  st;
  hct_pkg::hct_state_t  st_next;
  hct_pkg::hct_result_t step_result;
  hct_pkg::hct_result_t res;
  logic                 in_fire;
  logic                 cfg_write;
  logic [hct_pkg::REG_IDX_W-1:0] reg_idx;

  // The result register frees up in the same cycle it is taken, so a new
  // beat is accepted whenever the slot is empty or being drained.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // The port never inserts wait states; a write lands on the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = paddr[4:2];

  hct_step u_step (
    .cfg         (cfg),
    .st          (st),
    .mode        (mode),
    .temperature (temperature),
    .st_next     (st_next),
    .result      (step_result)
  );

  // Configuration registers. Each write is masked to its register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_limit    <= '0;
      cfg.upper_limit    <= '0;
      cfg.hysteresis     <= hct_pkg::HYST_RESET;
      cfg.min_heater_on  <= hct_pkg::MIN_RESET;
      cfg.min_heater_off <= hct_pkg::MIN_RESET;
      cfg.min_cooler_on  <= hct_pkg::MIN_RESET;
      cfg.min_cooler_off <= hct_pkg::MIN_RESET;
      cfg.limits_valid   <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        hct_pkg::REG_LOWER_LIMIT:    cfg.lower_limit    <= pwdata[hct_pkg::TEMP_W-1:0];
        hct_pkg::REG_UPPER_LIMIT:    cfg.upper_limit    <= pwdata[hct_pkg::TEMP_W-1:0];
        hct_pkg::REG_HYSTERESIS:     cfg.hysteresis     <= pwdata[hct_pkg::HYST_W-1:0];
        hct_pkg::REG_MIN_HEATER_ON:  cfg.min_heater_on  <= pwdata[hct_pkg::MIN_W-1:0];
        hct_pkg::REG_MIN_HEATER_OFF: cfg.min_heater_off <= pwdata[hct_pkg::MIN_W-1:0];
        hct_pkg::REG_MIN_COOLER_ON:  cfg.min_cooler_on  <= pwdata[hct_pkg::MIN_W-1:0];
        hct_pkg::REG_MIN_COOLER_OFF: cfg.min_cooler_off <= pwdata[hct_pkg::MIN_W-1:0];
        hct_pkg::REG_LIMITS_VALID:   cfg.limits_valid   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux. Limits come back as their raw two's complement bits.
  always_comb begin
    case (reg_idx)
      hct_pkg::REG_LOWER_LIMIT:    prdata = 32'(unsigned'(cfg.lower_limit));
      hct_pkg::REG_UPPER_LIMIT:    prdata = 32'(unsigned'(cfg.upper_limit));
      hct_pkg::REG_HYSTERESIS:     prdata = 32'(cfg.hysteresis);
      hct_pkg::REG_MIN_HEATER_ON:  prdata = 32'(cfg.min_heater_on);
      hct_pkg::REG_MIN_HEATER_OFF: prdata = 32'(cfg.min_heater_off);
      hct_pkg::REG_MIN_COOLER_ON:  prdata = 32'(cfg.min_cooler_on);
      hct_pkg::REG_MIN_COOLER_OFF: prdata = 32'(cfg.min_cooler_off);
      hct_pkg::REG_LIMITS_VALID:   prdata = 32'(cfg.limits_valid);
      default:                     prdata = '0;
    endcase
  end

  // Thermostat state advances once per accepted beat, so the next beat in
  // the following cycle already sees the updated drives and ages.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= step_result;
    end
  end

  assign heater_drive  = res.heater_drive;
  assign cooler_drive  = res.cooler_drive;
  assign relay_mask    = res.relay_mask;
  assign drive_changed = res.drive_changed;
  assign evaluated     = res.evaluated;

  // Heating and cooling are exclusive states of the controller.
  `ASSERT_NEVER(a_drive_exclusive, clk, rst, st.heater_state && st.cooler_state)
  // The relay mask shown always follows the drive bits of the same beat.
  `ASSERT_CLK(a_mask_follows, clk, rst,
              out_valid |-> (relay_mask == {cooler_drive, cooler_drive,
                                            heater_drive, heater_drive}))
  // A drive can only change on a beat where the rules actually ran.
  `ASSERT_CLK(a_change_needs_eval, clk, rst, (out_valid && drive_changed) |-> evaluated)
  // A reading beat yields a result that never reports evaluation.
  `ASSERT_CLK(a_reading_no_eval, clk, rst,
              (in_fire && !mode) |=> (out_valid && !evaluated && !drive_changed))

endmodule

// File: tb/heat_cool_thermostat_test.sv
// ----------------------------------------------------------------------------
// heat_cool_thermostat_test
// Self-checking bench for the heat/cool thermostat. Readings and control
// ticks go in on a valid/ready channel, every item is predicted by a local
// model of the thermostat, and each result beat is checked field by field.
// Registers are reprogrammed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module heat_cool_thermostat_test;

  localparam logic MODE_READING   = 1'b0;
  localparam logic MODE_TICK      = 1'b1;
  localparam int   TEMP_HI        = 2 ** (hct_pkg::TEMP_W - 1) - 1;
  localparam int   TEMP_LO        = -(2 ** (hct_pkg::TEMP_W - 1));
  localparam int   MIN_MAX        = 2 ** hct_pkg::MIN_W - 1;
  localparam int   CYCLE_LIMIT    = 400000;

  typedef struct {
    logic                              mode;
    logic signed [hct_pkg::TEMP_W-1:0] temperature;
  } thermo_item_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              mode = MODE_READING;
  logic signed [hct_pkg::TEMP_W-1:0] temperature = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              heater_drive;
  logic                              cooler_drive;
  logic [3:0]                        relay_mask;
  logic                              drive_changed;
  logic                              evaluated;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [4:0]                        paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  heat_cool_thermostat dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .temperature(temperature),
    .out_valid(out_valid), .out_ready(out_ready),
    .heater_drive(heater_drive), .cooler_drive(cooler_drive), .relay_mask(relay_mask),
    .drive_changed(drive_changed), .evaluated(evaluated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the register file, starting from the reset values.
  logic signed [hct_pkg::TEMP_W-1:0] cfg_lo = '0;
  logic signed [hct_pkg::TEMP_W-1:0] cfg_hi = '0;
  logic [hct_pkg::HYST_W-1:0]        cfg_band = hct_pkg::HYST_RESET;
  logic [hct_pkg::MIN_W-1:0]         cfg_heat_min_run = hct_pkg::MIN_RESET;
  logic [hct_pkg::MIN_W-1:0]         cfg_heat_min_rest = hct_pkg::MIN_RESET;
  logic [hct_pkg::MIN_W-1:0]         cfg_cool_min_run = hct_pkg::MIN_RESET;
  logic [hct_pkg::MIN_W-1:0]         cfg_cool_min_rest = hct_pkg::MIN_RESET;
  logic                              cfg_armed = 1'b0;

  // Local copy of the thermostat state.
  logic signed [hct_pkg::TEMP_W-1:0] temp_held = '0;
  logic                              have_reading = 1'b0;
  logic                              heat_on = 1'b0;
  logic                              cool_on = 1'b0;
  logic [hct_pkg::AGE_W-1:0]         heat_run_age = '0;
  logic [hct_pkg::AGE_W-1:0]         heat_rest_age = '0;
  logic [hct_pkg::AGE_W-1:0]         cool_run_age = '0;
  logic [hct_pkg::AGE_W-1:0]         cool_rest_age = '0;

  thermo_item_t          pending_items[$];
  hct_pkg::hct_result_t  expected_drive[$];
  int                    items_queued = 0;
  int                    items_taken = 0;
  int                    fail_count = 0;
  int                    cycle_count = 0;
  // Chance, in percent, that a new idle burst starts on the input or output side.
  int                    in_idle_pct = 0;
  int                    out_idle_pct = 0;
  int                    in_gap = 0;
  int                    out_stall = 0;
  thermo_item_t          on_wire;

  // Applies one item to the local state and returns the result beat it causes.
  // The age counters only move on ticks, and the control rules only run once a
  // reading exists and the limits are marked valid.
  function automatic hct_pkg::hct_result_t advance_thermostat(thermo_item_t item);
    hct_pkg::hct_result_t r;
    logic        heat_was, cool_was, ran;
    logic        want_heat, want_cool, held_long, other_rested;
    int          t, h, lo, hi;
    heat_was = heat_on;
    cool_was = cool_on;
    ran = 1'b0;
    if (item.mode == MODE_READING) begin
      temp_held = item.temperature;
      have_reading = 1'b1;
    end else begin
      if (heat_run_age != hct_pkg::AGE_MAX) heat_run_age++;
      if (heat_rest_age != hct_pkg::AGE_MAX) heat_rest_age++;
      if (cool_run_age != hct_pkg::AGE_MAX) cool_run_age++;
      if (cool_rest_age != hct_pkg::AGE_MAX) cool_rest_age++;
      if (have_reading && cfg_armed) begin
        ran = 1'b1;
        t = temp_held;
        h = cfg_band;
        lo = cfg_lo;
        hi = cfg_hi;
        // Band edges are plain integer sums, so they never wrap.
        want_heat = (t <= lo - h);
        want_cool = (t >= hi + h);
        if (heat_on) begin
          held_long = (heat_run_age >= cfg_heat_min_run);
          other_rested = (cool_rest_age >= cfg_cool_min_rest);
          if (held_long && t >= lo + h) begin
            heat_on = 1'b0;
            heat_rest_age = '0;
          end
          // A heater that did not stop may hand over straight to the cooler.
          if (heat_on && held_long && want_cool && other_rested) begin
            heat_on = 1'b0;
            heat_rest_age = '0;
            cool_on = 1'b1;
            cool_run_age = '0;
          end
        end else if (cool_on) begin
          held_long = (cool_run_age >= cfg_cool_min_run);
          other_rested = (heat_rest_age >= cfg_heat_min_rest);
          if (held_long && t <= hi - h) begin
            cool_on = 1'b0;
            cool_rest_age = '0;
          end
          if (cool_on && held_long && want_heat && other_rested) begin
            cool_on = 1'b0;
            cool_rest_age = '0;
            heat_on = 1'b1;
            heat_run_age = '0;
          end
        end else if (want_heat && heat_rest_age >= cfg_heat_min_rest) begin
          heat_on = 1'b1;
          heat_run_age = '0;
        end else if (want_cool && cool_rest_age >= cfg_cool_min_rest) begin
          cool_on = 1'b1;
          cool_run_age = '0;
        end
      end
    end
    r.heater_drive = heat_on;
    r.cooler_drive = cool_on;
    r.relay_mask = {cool_on, cool_on, heat_on, heat_on};
    r.drive_changed = (heat_on != heat_was) || (cool_on != cool_was);
    r.evaluated = ran;
    return r;
  endfunction

  function automatic void queue_item(logic m, int t);
    thermo_item_t item;
    item.mode = m;
    item.temperature = t[hct_pkg::TEMP_W-1:0];
    pending_items.push_back(item);
    items_queued++;
  endfunction

  // Fills the bits above a register's width with noise; the block must drop them.
  function automatic logic [31:0] pad_upper_bits(int value, int w);
    logic [31:0] mask;
    mask = (32'd1 << w) - 32'd1;
    return ($urandom & ~mask) | (32'(value) & mask);
  endfunction

  // One APB write: a setup cycle, then an access cycle that completes at the
  // edge where pready is seen high. The local register copy follows at that edge.
  task automatic write_reg(logic [hct_pkg::REG_IDX_W-1:0] idx, logic [31:0] word);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      hct_pkg::REG_LOWER_LIMIT:    cfg_lo = word[hct_pkg::TEMP_W-1:0];
      hct_pkg::REG_UPPER_LIMIT:    cfg_hi = word[hct_pkg::TEMP_W-1:0];
      hct_pkg::REG_HYSTERESIS:     cfg_band = word[hct_pkg::HYST_W-1:0];
      hct_pkg::REG_MIN_HEATER_ON:  cfg_heat_min_run = word[hct_pkg::MIN_W-1:0];
      hct_pkg::REG_MIN_HEATER_OFF: cfg_heat_min_rest = word[hct_pkg::MIN_W-1:0];
      hct_pkg::REG_MIN_COOLER_ON:  cfg_cool_min_run = word[hct_pkg::MIN_W-1:0];
      hct_pkg::REG_MIN_COOLER_OFF: cfg_cool_min_rest = word[hct_pkg::MIN_W-1:0];
      hct_pkg::REG_LIMITS_VALID:   cfg_armed = word[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_all(int lo, int hi, int band, int heat_run, int heat_rest,
                         int cool_run, int cool_rest, int armed);
    write_reg(hct_pkg::REG_LOWER_LIMIT, pad_upper_bits(lo, hct_pkg::TEMP_W));
    write_reg(hct_pkg::REG_UPPER_LIMIT, pad_upper_bits(hi, hct_pkg::TEMP_W));
    write_reg(hct_pkg::REG_HYSTERESIS, pad_upper_bits(band, hct_pkg::HYST_W));
    write_reg(hct_pkg::REG_MIN_HEATER_ON, pad_upper_bits(heat_run, hct_pkg::MIN_W));
    write_reg(hct_pkg::REG_MIN_HEATER_OFF, pad_upper_bits(heat_rest, hct_pkg::MIN_W));
    write_reg(hct_pkg::REG_MIN_COOLER_ON, pad_upper_bits(cool_run, hct_pkg::MIN_W));
    write_reg(hct_pkg::REG_MIN_COOLER_OFF, pad_upper_bits(cool_rest, hct_pkg::MIN_W));
    write_reg(hct_pkg::REG_LIMITS_VALID, pad_upper_bits(armed, 1));
  endtask

  // Waits until every queued item was taken and every result beat came back.
  // Each item gives exactly one result, so the block is idle at that point.
  task automatic drain();
    while (items_taken != items_queued || expected_drive.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Input driver. The accepted beat is predicted at the edge where it is taken,
  // so its expectation is always queued before the result can come back.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_drive.push_back(advance_thermostat(on_wire));
        items_taken++;
      end
      // A beat that is still waiting for ready stays on the wire untouched.
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(99) < in_idle_pct) begin
          in_gap = $urandom_range(10, 1) - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_wire = pending_items.pop_front();
          in_valid <= 1'b1;
          mode <= on_wire.mode;
          temperature <= on_wire.temperature;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure in bursts.
  always @(posedge clk) begin
    hct_pkg::hct_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_drive.pop_front();
          if (heater_drive !== want.heater_drive) begin
            $display("%0t: heater_drive expected %0d actual %0d", $time,
                     want.heater_drive, heater_drive);
            fail_count++;
          end
          if (cooler_drive !== want.cooler_drive) begin
            $display("%0t: cooler_drive expected %0d actual %0d", $time,
                     want.cooler_drive, cooler_drive);
            fail_count++;
          end
          if (relay_mask !== want.relay_mask) begin
            $display("%0t: relay_mask expected %h actual %h", $time,
                     want.relay_mask, relay_mask);
            fail_count++;
          end
          if (drive_changed !== want.drive_changed) begin
            $display("%0t: drive_changed expected %0d actual %0d", $time,
                     want.drive_changed, drive_changed);
            fail_count++;
          end
          if (evaluated !== want.evaluated) begin
            $display("%0t: evaluated expected %0d actual %0d", $time,
                     want.evaluated, evaluated);
            fail_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_stall = $urandom_range(10, 1) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int lo, hi, band, heat_run, heat_rest, cool_run, cool_rest, armed;
    int p, k, n, t, swap, reach;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First with the reset register values: limits are not
    // valid yet, so ticks only age the counters and nothing is evaluated,
    // both before and after the first reading.
    in_idle_pct = 30;
    out_idle_pct = 30;
    queue_item(MODE_TICK, 0);
    queue_item(MODE_READING, TEMP_HI);
    queue_item(MODE_TICK, 0);
    drain();

    // A normal band of 10.0 to 20.0 degrees with short minimum times: start
    // heating from the coldest reading, hold for the minimum on time, stop when
    // it gets hot, then start and stop the cooler.
    set_all(100, 200, 5, 2, 0, 2, 0, 1);
    queue_item(MODE_READING, TEMP_LO);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_READING, TEMP_HI);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_READING, 150);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    drain();

    // Inverted band with no hysteresis: heat and cool are both wanted inside
    // it, so the drive flips straight between heater and cooler.
    set_all(200, 100, 0, 1, 1, 1, 1, 1);
    queue_item(MODE_READING, 150);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_TICK, 0);
    drain();

    // Largest minimum times: the ages are far below them, so neither a cold
    // nor a hot reading can start a drive.
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_all(-100, 100, 0, MIN_MAX, MIN_MAX, MIN_MAX, MIN_MAX, 1);
    queue_item(MODE_READING, TEMP_LO);
    queue_item(MODE_TICK, 0);
    queue_item(MODE_READING, TEMP_HI);
    queue_item(MODE_TICK, 0);
    drain();

    // Random phases. Most readings land within the hysteresis plus four of a band edge so
    // that the drive actually moves; the rest are arbitrary bit patterns.
    for (p = 0; p < 8; p++) begin
      in_idle_pct = (p % 3 == 0 || p == 7) ? 0 : 20;
      out_idle_pct = (p % 3 == 1 || p == 7) ? 0 : 25;
      heat_run = $urandom_range(6);
      heat_rest = $urandom_range(6);
      cool_run = $urandom_range(6);
      cool_rest = $urandom_range(6);
      armed = 1;
      case (p)
        0: begin
          lo = TEMP_LO;
          hi = TEMP_HI;
          band = 0;
          heat_run = 0;
          heat_rest = 0;
          cool_run = 0;
          cool_rest = 0;
        end
        1: begin
          lo = TEMP_HI;
          hi = TEMP_LO;
          band = 2 ** hct_pkg::HYST_W - 1;
        end
        2: begin
          // Limits marked invalid: ages run but the rules stay asleep.
          lo = -50;
          hi = 50;
          band = 3;
          heat_run = MIN_MAX;
          heat_rest = MIN_MAX;
          cool_run = MIN_MAX;
          cool_rest = MIN_MAX;
          armed = 0;
        end
        default: begin
          t = int'($urandom_range(3600)) - 1800;
          lo = t - int'($urandom_range(60));
          hi = t + int'($urandom_range(60));
          if ($urandom_range(4) == 0) begin
            swap = lo;
            lo = hi;
            hi = swap;
          end
          band = ($urandom_range(6) == 0) ? 2 ** hct_pkg::HYST_W - 1 : $urandom_range(12);
          armed = ($urandom_range(9) != 0);
        end
      endcase
      set_all(lo, hi, band, heat_run, heat_rest, cool_run, cool_rest, armed);
      n = (p == 7) ? 150 : 100;
      reach = band + 4;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(99) < 35) begin
          if ($urandom_range(3) == 0) begin
            t = $urandom_range(4095);
          end else begin
            t = ($urandom_range(1) ? lo : hi) + int'($urandom_range(2 * reach)) - reach;
            if (t > TEMP_HI) t = TEMP_HI;
            if (t < TEMP_LO) t = TEMP_LO;
          end
          queue_item(MODE_READING, t);
        end else begin
          // The temperature field carries noise on ticks; it must be ignored.
          queue_item(MODE_TICK, $urandom_range(4095));
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
